FILE: hw/rtl/phni_pkg.sv
package phni_pkg;

    localparam logic [31:0] NOP_WORD   = 32'h0000_0033;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_REG    = 7'b0110011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [1:0] MAX_NOPS = 2'd2;

    typedef struct packed {
        logic       writes;
        logic       is_load;
        logic [4:0] rd;
    } t_writer;

    typedef struct packed {
        logic [1:0] nops;
        t_writer    wr;
    } t_dec;

endpackage

FILE: hw/rtl/pipeline_hazard_nop_inserter_core.sv
// Hazard NOP inserter for an RV32I pipeline. Each input item is one
// instruction word; the block emits 0x00000033 NOPs as needed to clear data
// hazards against the two previously emitted instructions (two NOPs for a
// dependence on the last one, one for the one before; with forwarding only
// load-use costs one NOP; every jal gets one NOP), then the word itself with
// o_last_of_run set. An item goes from the input register through decode into
// the output register; o_in_stall holds the input register while NOPs are
// inserted or the output stalls, so a stream runs at one item per cycle only
// when neither occurs, limited by the single output register. Write
// forwarding_enable (bit 0 of i_cfg_data) only while the block is idle.
module pipeline_hazard_nop_inserter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_out_word,
    output logic        o_is_inserted_nop,
    output logic        o_last_of_run
);
    import phni_pkg::*;

    logic        r_fwd_en;
    logic        r_in_vld;
    logic [31:0] r_in_word;
    logic [1:0]  r_cnt;
    t_writer     r_slot0;
    t_writer     r_slot1;
    logic        r_out_vld;
    logic [31:0] r_out_word;
    logic        r_out_nop;
    logic        r_out_last;

    t_dec        dec;
    logic        out_free;
    logic        move;
    logic        emit_instr;

    phni_decode u_decode (
        .i_word   (r_in_word),
        .i_fwd_en (r_fwd_en),
        .i_slot0  (r_slot0),
        .i_slot1  (r_slot1),
        .o_dec    (dec)
    );

    assign out_free   = !r_out_vld || !i_out_stall;
    assign move       = r_in_vld && out_free;
    assign emit_instr = r_cnt >= dec.nops;
    assign o_in_stall = r_in_vld && !(move && emit_instr);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid       = r_out_vld;
    assign o_out_word        = r_out_word;
    assign o_is_inserted_nop = r_out_nop;
    assign o_last_of_run     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en  <= 1'b0;
            r_in_vld  <= 1'b0;
            r_cnt     <= 2'd0;
            r_slot0   <= '0;
            r_slot1   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_fwd_en <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= move;
            end
            if (move) begin
                if (emit_instr) begin
                    r_cnt   <= 2'd0;
                    r_slot0 <= dec.wr;
                    r_slot1 <= (dec.nops != 2'd0) ? t_writer'('0) : r_slot0;
                end else begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_instr_word;
        end
        if (move) begin
            r_out_word <= emit_instr ? r_in_word : NOP_WORD;
            r_out_nop  <= !emit_instr;
            r_out_last <= emit_instr;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_NOPS)
        else $error("nop counter out of range");

    a_out_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_nop != r_out_last))
        else $error("result is neither or both nop and instruction");

    a_slot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && emit_instr && dec.nops != 2'd0) |=> !r_slot1.writes)
        else $error("writer survived an inserted nop");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> r_cnt == 2'd0)
        else $error("nop count held without an item");

endmodule

FILE: hw/rtl/phni_decode.sv
module phni_decode (
    input  logic [31:0]       i_word,
    input  logic              i_fwd_en,
    input  phni_pkg::t_writer i_slot0,
    input  phni_pkg::t_writer i_slot1,
    output phni_pkg::t_dec    o_dec
);
    import phni_pkg::*;

    logic [6:0] opc;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic       reads1;
    logic       reads2;
    logic       may_write;
    logic       is_load;
    logic       is_jal;
    logic       dep0;
    logic       dep1;

    assign opc = i_word[6:0];
    assign rd  = i_word[11:7];
    assign rs1 = i_word[19:15];
    assign rs2 = i_word[24:20];

    always_comb begin
        reads1    = 1'b0;
        reads2    = 1'b0;
        may_write = 1'b0;
        is_load   = 1'b0;
        is_jal    = 1'b0;
        unique case (opc)
            OPC_REG: begin
                reads1 = 1'b1; reads2 = 1'b1; may_write = 1'b1;
            end
            OPC_JALR, OPC_IMM, OPC_FENCE, OPC_SYSTEM: begin
                reads1 = 1'b1; may_write = 1'b1;
            end
            OPC_LOAD: begin
                reads1 = 1'b1; may_write = 1'b1; is_load = 1'b1;
            end
            OPC_STORE, OPC_BRANCH: begin
                reads1 = 1'b1; reads2 = 1'b1;
            end
            OPC_LUI, OPC_AUIPC: begin
                may_write = 1'b1;
            end
            OPC_JAL: begin
                may_write = 1'b1; is_jal = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_word == ECALL_WORD) begin
            reads1 = 1'b0;
            reads2 = 1'b0;
        end
    end

    assign dep0 = i_slot0.writes && ((reads1 && i_slot0.rd == rs1) || (reads2 && i_slot0.rd == rs2));
    assign dep1 = i_slot1.writes && ((reads1 && i_slot1.rd == rs1) || (reads2 && i_slot1.rd == rs2));

    always_comb begin
        priority if (is_jal) begin
            o_dec.nops = 2'd1;
        end else if (i_fwd_en) begin
            o_dec.nops = (i_slot0.is_load && dep0) ? 2'd1 : 2'd0;
        end else if (dep0) begin
            o_dec.nops = MAX_NOPS;
        end else if (dep1) begin
            o_dec.nops = 2'd1;
        end else begin
            o_dec.nops = 2'd0;
        end
        o_dec.wr.writes  = may_write && (rd != 5'd0);
        o_dec.wr.is_load = o_dec.wr.writes && is_load;
        o_dec.wr.rd      = o_dec.wr.writes ? rd : 5'd0;
    end

endmodule
